/* rtl/mbb_pkg.sv */
// mbb_pkg: shared types and constants for the mono bitmap masked blit
// no dependencies; used by mbb_cfg, mbb_clip and the top level

package mbb_pkg;

    // item modes
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_BLIT  = 2'd2
    } t_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CANVAS_WIDTH  = 3'd0,
        CFG_CANVAS_HEIGHT = 3'd1,
        CFG_ROW_STRIDE    = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4,
        CFG_OFFSET_X      = 3'd5,
        CFG_OFFSET_Y      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]        canvas_width;
        logic [9:0]        canvas_height;
        logic [6:0]        row_stride_bytes;
        logic [6:0]        image_width;
        logic [6:0]        image_height;
        logic signed [9:0] offset_x;
        logic signed [9:0] offset_y;
    } t_cfg;

    // per source word: clip mask over two canvas bytes and their position
    typedef struct packed {
        logic [15:0]       mask16;
        logic signed [7:0] xb;
        logic [9:0]        py;
    } t_blit;

    localparam logic [9:0] RST_CANVAS_WIDTH  = 10'd128;
    localparam logic [9:0] RST_CANVAS_HEIGHT = 10'd64;
    localparam logic [6:0] RST_ROW_STRIDE    = 7'd16;
    localparam logic [6:0] RST_IMAGE_WIDTH   = 7'd32;
    localparam logic [6:0] RST_IMAGE_HEIGHT  = 7'd32;
    localparam logic [9:0] RST_OFFSET_X      = 10'd24;
    localparam logic [9:0] RST_OFFSET_Y      = 10'h3EE;

endpackage

/* rtl/mbb_if.sv */
// mbb_if: valid/ready channel interfaces of the mono bitmap masked blit
// depends on nothing; the top level and the config register file use them

interface mbb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [9:0] byte_address;
    logic [7:0] byte_data;
    logic [5:0] source_row;
    logic [2:0] source_byte_column;

    modport source (output valid, mode, byte_address, byte_data, source_row,
                    source_byte_column, input ready);
    modport sink (input valid, mode, byte_address, byte_data, source_row,
                  source_byte_column, output ready);
endinterface

interface mbb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

interface mbb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mbb_ram.sv */
// mbb_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module mbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mbb_cfg.sv */
// mbb_cfg: configuration register file of the blit
// depends on mbb_pkg and mbb_cfg_if

module mbb_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mbb_cfg_if.sink        i_cfg,
    output mbb_pkg::t_cfg  o_cfg
);

    mbb_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width     <= mbb_pkg::RST_CANVAS_WIDTH;
            r_cfg.canvas_height    <= mbb_pkg::RST_CANVAS_HEIGHT;
            r_cfg.row_stride_bytes <= mbb_pkg::RST_ROW_STRIDE;
            r_cfg.image_width      <= mbb_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height     <= mbb_pkg::RST_IMAGE_HEIGHT;
            r_cfg.offset_x         <= $signed(mbb_pkg::RST_OFFSET_X);
            r_cfg.offset_y         <= $signed(mbb_pkg::RST_OFFSET_Y);
        end else if (i_cfg.valid) begin
            case (mbb_pkg::t_cfg_idx'(i_cfg.index))
                mbb_pkg::CFG_CANVAS_WIDTH:  r_cfg.canvas_width     <= i_cfg.data;
                mbb_pkg::CFG_CANVAS_HEIGHT: r_cfg.canvas_height    <= i_cfg.data;
                mbb_pkg::CFG_ROW_STRIDE:    r_cfg.row_stride_bytes <= i_cfg.data[6:0];
                mbb_pkg::CFG_IMAGE_WIDTH:   r_cfg.image_width      <= i_cfg.data[6:0];
                mbb_pkg::CFG_IMAGE_HEIGHT:  r_cfg.image_height     <= i_cfg.data[6:0];
                mbb_pkg::CFG_OFFSET_X:      r_cfg.offset_x         <= $signed(i_cfg.data);
                mbb_pkg::CFG_OFFSET_Y:      r_cfg.offset_y         <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/mbb_clip.sv */
// mbb_clip: per-pixel clipping of one source byte against image and canvas
// depends on mbb_pkg

module mbb_clip #(
    parameter int MAX_IMAGE_WIDTH = 64
) (
    input  mbb_pkg::t_cfg  i_cfg,
    input  logic [5:0]     i_row,
    input  logic [2:0]     i_col,
    input  logic [7:0]     i_data,
    output mbb_pkg::t_blit o_blit
);

    localparam logic [8:0] MAX_W = 9'(MAX_IMAGE_WIDTH);

    logic signed [10:0] x0;
    logic signed [10:0] py;
    logic signed [10:0] px;
    logic [5:0]         sx;
    logic               row_ok;
    logic [7:0]         v;

    always_comb begin
        x0 = {i_cfg.offset_x[9], i_cfg.offset_x} + {2'b00, i_col, 3'b000};
        py = {i_cfg.offset_y[9], i_cfg.offset_y} + {5'b00000, i_row};
        row_ok = ({1'b0, i_row} < i_cfg.image_height) && !py[10]
                 && (py[9:0] < i_cfg.canvas_height);
        px = x0;
        sx = '0;
        v  = '0;
        // pixel b of the word sits at bit 7-b, msb first
        for (int b = 0; b < 8; b++) begin
            px = x0 + {8'b0, 3'(b)};
            sx = {i_col, 3'(b)};
            v[3'(7 - b)] = i_data[3'(7 - b)] && row_ok
                           && ({1'b0, sx} < i_cfg.image_width)
                           && ({3'b000, sx} < MAX_W)
                           && !px[10] && (px[9:0] < i_cfg.canvas_width);
        end
        // spread over the two canvas bytes the word straddles
        o_blit.mask16 = {v, 8'h00} >> x0[2:0];
        o_blit.xb     = x0[10:3];
        o_blit.py     = py[9:0];
    end

endmodule

/* rtl/mono_bitmap_masked_blit_top.sv */
// mono_bitmap_masked_blit_top: 1bpp canvas store with transparent blit
// depends on mbb_pkg, mbb_if, mbb_ram, mbb_cfg and mbb_clip
//
// usage
//   i_cfg : register writes (index, data), always ready; write only while idle
//   i_in  : items; mode 0 writes a canvas byte, mode 1 reads one, mode 2 blits
//           one source image byte (row, byte column) clearing canvas bits
//   o_out : one word per item; read_data is the canvas byte for mode 1, else 0
// timing
//   mode 0 and unused mode 3: result valid in the cycle after accept
//   mode 1: one ram read, then the registered output word
//   mode 2: clip and row multiply, address, then read-modify-write of
//           the two canvas bytes the word straddles, through one ram port
//   one item at a time: a new word is taken once the sequencer is idle and the
//   output register is empty or being emptied
// reset
//   config registers return to defaults, sequencer idles, output empties;
//   the canvas store is not cleared and must be written before it is read
// stall
//   a stalled result holds in the output register and input ready drops

module mono_bitmap_masked_blit_top #(
    parameter int CANVAS_BYTES    = 1024,
    parameter int MAX_IMAGE_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbb_cfg_if.sink   i_cfg,
    mbb_in_if.sink    i_in,
    mbb_out_if.source o_out
);

    localparam int          AW = $clog2(CANVAS_BYTES);
    localparam logic [17:0] CB = 18'(CANVAS_BYTES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDOUT = 7'b0000010,
        S_CALC  = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_RDA   = 7'b0010000,
        S_WRA   = 7'b0100000,
        S_WRB   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    mbb_pkg::t_cfg  cfg;
    mbb_pkg::t_blit blit;

    logic [5:0]         r_row;
    logic [2:0]         r_col;
    logic [7:0]         r_data;
    logic               r_addr_ok;
    logic [15:0]        r_mask;
    logic signed [7:0]  r_xb;
    logic [16:0]        r_base;
    logic [17:0]        r_idx_a, r_idx_b;
    logic               r_ok_a, r_ok_b;
    logic               r_out_valid;
    logic [7:0]         r_out_data;

    logic               accept;
    logic               addr_ok;
    logic [16:0]        addr_ext;
    logic [17:0]        n_idx_a;
    logic               load_out;
    logic [7:0]         load_data;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [7:0]         mem_wdata, mem_rdata;

    mbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mbb_clip #(
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_clip (
        .i_cfg  (cfg),
        .i_row  (r_row),
        .i_col  (r_col),
        .i_data (r_data),
        .o_blit (blit)
    );

    mbb_ram #(
        .WIDTH (8),
        .DEPTH (CANVAS_BYTES)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign addr_ext   = {7'b0, i_in.byte_address};
    assign addr_ok    = {1'b0, addr_ext} < CB;
    assign n_idx_a    = {1'b0, r_base} + {{10{r_xb[7]}}, r_xb};

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = addr_ext[AW-1:0];
        mem_raddr = addr_ext[AW-1:0];
        mem_wdata = i_in.byte_data;
        load_out  = 1'b0;
        load_data = 8'h00;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (mbb_pkg::t_mode'(i_in.mode))
                        mbb_pkg::MODE_WRITE: begin
                            mem_we   = addr_ok;
                            load_out = 1'b1;
                        end
                        mbb_pkg::MODE_READ: begin
                            mem_re  = 1'b1;
                            n_state = S_RDOUT;
                        end
                        mbb_pkg::MODE_BLIT: begin
                            n_state = S_CALC;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                load_out  = 1'b1;
                load_data = r_addr_ok ? mem_rdata : 8'h00;
                n_state   = S_IDLE;
            end
            S_CALC: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_RDA;
            end
            S_RDA: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx_a[AW-1:0];
                n_state   = S_WRA;
            end
            S_WRA: begin
                // write back the left byte while fetching the right one
                mem_we    = r_ok_a;
                mem_waddr = r_idx_a[AW-1:0];
                mem_wdata = mem_rdata & ~r_mask[15:8];
                mem_re    = 1'b1;
                mem_raddr = r_idx_b[AW-1:0];
                n_state   = S_WRB;
            end
            S_WRB: begin
                mem_we    = r_ok_b;
                mem_waddr = r_idx_b[AW-1:0];
                mem_wdata = mem_rdata & ~r_mask[7:0];
                load_out  = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row     <= i_in.source_row;
            r_col     <= i_in.source_byte_column;
            r_data    <= i_in.byte_data;
            r_addr_ok <= addr_ok;
        end
        if (r_state == S_CALC) begin
            r_mask <= blit.mask16;
            r_xb   <= blit.xb;
            r_base <= {7'b0, blit.py} * {10'b0, cfg.row_stride_bytes};
        end
        if (r_state == S_ADDR) begin
            r_idx_a <= n_idx_a;
            r_idx_b <= n_idx_a + 18'd1;
            r_ok_a  <= (|r_mask[15:8]) && (n_idx_a < CB);
            r_ok_b  <= (|r_mask[7:0]) && ((n_idx_a + 18'd1) < CB);
        end
        if (load_out) begin
            r_out_data <= load_data;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;

`ifndef SYNTHESIS
    // the single write port never targets the byte being fetched
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("canvas read and write hit the same byte");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.mode == mbb_pkg::MODE_READ)) |=> ##1 o_out.valid)
        else $error("read result not delivered two cycles after accept");

    a_blit_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.mode == mbb_pkg::MODE_BLIT)) |=> ##5 o_out.valid)
        else $error("blit result not delivered six cycles after accept");
`endif

endmodule
